// ----- rtl/core/shp_pkg.sv -----
`timescale 1ns / 1ps

package shp_pkg;

	// Width of the internal position and target counters.
	localparam int unsigned POSITION_BITS = 16;

	localparam int unsigned FIELD_BITS  = 16;
	localparam int unsigned CFG_BITS    = 8;
	localparam int unsigned CFG_IDX_BITS = 2;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_BITS  = $clog2(PHASES);

	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [FIELD_BITS-1:0]    field_t;
	typedef logic [PHASE_BITS-1:0]    phase_t;
	typedef logic [3:0]               coils_t;

	typedef logic [1:0] action_t;
	localparam action_t ACT_MOTOR_TICK = 2'd0;
	localparam action_t ACT_SWEEP_TICK = 2'd1;
	localparam action_t ACT_SET_TARGET = 2'd2;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_STEP_DIVIDER     = 2'd0;
	localparam cfg_idx_t CFG_OVERSHOOT_PULSES = 2'd1;
	localparam cfg_idx_t CFG_DWELL_TICKS      = 2'd2;

	localparam logic [CFG_BITS-1:0] STEP_DIVIDER_RESET     = 8'd16;
	localparam logic [CFG_BITS-1:0] OVERSHOOT_PULSES_RESET = 8'd8;
	localparam logic [CFG_BITS-1:0] DWELL_TICKS_RESET      = 8'd200;

	localparam coils_t COILS_OFF = 4'h0;

	typedef struct packed {
		logic [CFG_BITS-1:0] step_divider;
		logic [CFG_BITS-1:0] overshoot_pulses;
		logic [CFG_BITS-1:0] dwell_ticks;
	} cfg_t;

	typedef struct packed {
		action_t action;
		logic    pause;
		field_t  limit_a;
		field_t  limit_b;
		field_t  new_target;
	} cmd_t;

	typedef struct packed {
		coils_t coils;
		field_t position;
		field_t target_pos;
		logic   sweep_up;
	} status_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] prescale_count;
		phase_t              phase_index;
		pos_t                position;
		pos_t                target;
		coils_t              coils;
		logic                sweep_dir;
		logic                overshoot_done;
		logic [CFG_BITS-1:0] dwell_count;
	} state_t;

	// Half-step coil pattern, bit0 is coil A.
	function automatic coils_t half_step_pattern(input phase_t idx);
		coils_t pat;
		case (idx)
			3'd0: pat = 4'h9;
			3'd1: pat = 4'h1;
			3'd2: pat = 4'h3;
			3'd3: pat = 4'h2;
			3'd4: pat = 4'h6;
			3'd5: pat = 4'h4;
			3'd6: pat = 4'hC;
			3'd7: pat = 4'h8;
			default: pat = COILS_OFF;
		endcase
		return pat;
	endfunction

endpackage

// ----- rtl/core/shp_if.sv -----
`timescale 1ns / 1ps

interface shp_cmd_if;
	logic          valid;
	logic          ready;
	shp_pkg::cmd_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface shp_status_if;
	logic             valid;
	logic             ready;
	shp_pkg::status_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/core/stepper_half_step_positioner.sv -----
`timescale 1ns / 1ps

// Channel   Dir   Handshake     Contents
// cmd       in    valid/ready   action, pause, limit_a, limit_b, new_target
// status    out   valid/ready   coils, position, target_pos, sweep_up
// cfg_*     in    write enable  step_divider, overshoot_pulses, dwell_ticks
//
// An accepted request is registered in the input register; the state update
// and status register load from it when status is empty or being drained.
// A new request is taken every cycle while status is drained.
// Reset clears the motor state and loads the register defaults.
// When status stalls, the input register holds one more request, then cmd
// ready drops.

module stepper_half_step_positioner (
	input  logic                      clk,
	input  logic                      arst_n,
	shp_cmd_if.sink                   cmd,
	shp_status_if.source              status,
	input  logic                      cfg_we,
	input  shp_pkg::cfg_idx_t         cfg_index,
	input  logic [shp_pkg::CFG_BITS-1:0] cfg_data
);

	shp_pkg::cfg_t    cfg_q;
	shp_pkg::state_t  state_q;
	shp_pkg::state_t  state_nx;
	shp_pkg::cmd_t    cmd_s1;
	logic             valid_s1;
	shp_pkg::status_t status_q;
	logic             status_valid_q;
	logic             advance_s1;

	assign advance_s1 = valid_s1 && (!status_valid_q || status.ready);
	assign cmd.ready  = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_divider     <= shp_pkg::STEP_DIVIDER_RESET;
			cfg_q.overshoot_pulses <= shp_pkg::OVERSHOOT_PULSES_RESET;
			cfg_q.dwell_ticks      <= shp_pkg::DWELL_TICKS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				shp_pkg::CFG_STEP_DIVIDER:     cfg_q.step_divider     <= cfg_data;
				shp_pkg::CFG_OVERSHOOT_PULSES: cfg_q.overshoot_pulses <= cfg_data;
				shp_pkg::CFG_DWELL_TICKS:      cfg_q.dwell_ticks      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= cmd.data;
		end
	end

	shp_step_logic u_step (
		.st  (state_q),
		.cfg (cfg_q),
		.cmd (cmd_s1),
		.nx  (state_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '0;
			status_valid_q <= 1'b0;
		end else begin
			if (advance_s1) begin
				state_q <= state_nx;
			end
			if (advance_s1) begin
				status_valid_q <= 1'b1;
			end else if (status.ready) begin
				status_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			status_q.coils      <= state_nx.coils;
			status_q.position   <= shp_pkg::field_t'(state_nx.position);
			status_q.target_pos <= shp_pkg::field_t'(state_nx.target);
			status_q.sweep_up   <= state_nx.sweep_dir;
		end
	end

	assign status.valid = status_valid_q;
	assign status.data  = status_q;

endmodule

// ----- rtl/core/shp_step_logic.sv -----
`timescale 1ns / 1ps

module shp_step_logic (
	input  shp_pkg::state_t st,
	input  shp_pkg::cfg_t   cfg,
	input  shp_pkg::cmd_t   cmd,
	output shp_pkg::state_t nx
);

	always_comb begin
		logic [shp_pkg::CFG_BITS-1:0] prescale_inc;
		logic [shp_pkg::CFG_BITS-1:0] dwell_inc;
		shp_pkg::field_t              lo;
		shp_pkg::field_t              hi;
		shp_pkg::pos_t                overshoot;
		shp_pkg::pos_t                sweep_target;

		nx           = st;
		prescale_inc = st.prescale_count + 1'b1;
		dwell_inc    = st.dwell_count + 1'b1;
		lo           = (cmd.limit_a < cmd.limit_b) ? cmd.limit_a : cmd.limit_b;
		hi           = (cmd.limit_a < cmd.limit_b) ? cmd.limit_b : cmd.limit_a;
		overshoot    = shp_pkg::pos_t'(cfg.overshoot_pulses);
		sweep_target = st.sweep_dir ? shp_pkg::pos_t'(hi) : shp_pkg::pos_t'(lo);

		case (cmd.action)
			shp_pkg::ACT_MOTOR_TICK: begin
				nx.prescale_count = prescale_inc;
				if (prescale_inc >= cfg.step_divider) begin
					nx.prescale_count = '0;
					if (cmd.pause) begin
						nx.coils = shp_pkg::COILS_OFF;
					end else begin
						// Stepping up walks the pattern backwards.
						if (st.position < st.target) begin
							nx.phase_index = st.phase_index - 1'b1;
							nx.position    = st.position + 1'b1;
						end else if (st.position > st.target) begin
							nx.phase_index = st.phase_index + 1'b1;
							nx.position    = st.position - 1'b1;
						end
						nx.coils = shp_pkg::half_step_pattern(nx.phase_index);
					end
				end
			end
			shp_pkg::ACT_SWEEP_TICK: begin
				nx.target = sweep_target;
				if (st.sweep_dir) begin
					if (st.position >= sweep_target) begin
						if (!st.overshoot_done) begin
							nx.overshoot_done = 1'b1;
							nx.position = (st.position >= overshoot) ?
								st.position - overshoot : '0;
						end else begin
							nx.dwell_count = dwell_inc;
							if (dwell_inc > cfg.dwell_ticks) begin
								nx.dwell_count = '0;
								nx.sweep_dir   = 1'b0;
							end
						end
					end
				end else begin
					if (st.position <= sweep_target) begin
						nx.dwell_count = dwell_inc;
						if (dwell_inc > cfg.dwell_ticks) begin
							nx.dwell_count    = '0;
							nx.sweep_dir      = 1'b1;
							nx.overshoot_done = 1'b0;
						end
					end
				end
			end
			shp_pkg::ACT_SET_TARGET: begin
				nx.target = shp_pkg::pos_t'(cmd.new_target);
			end
			default: begin
			end
		endcase
	end

endmodule
